>>> sv/ssub_pkg.sv
package ssub_pkg;

  localparam int COORD_BITS = 24;
  localparam int STEP_BITS  = 24;
  localparam int MAX_POINTS = 64;

  localparam int DW    = COORD_BITS + 1;
  localparam int PW    = 2 * DW;
  localparam int CW    = $clog2(DW);
  localparam int NW    = $clog2(MAX_POINTS) + 1;

  localparam logic [STEP_BITS-1:0] STEP_RESET = STEP_BITS'(256);

  localparam logic [1:0] OP_MUL  = 2'd0;
  localparam logic [1:0] OP_DIV  = 2'd1;
  localparam logic [1:0] OP_SQRT = 2'd2;

  typedef struct packed {
    logic          start;
    logic [1:0]    op;
    logic [PW-1:0] a;
    logic [DW-1:0] b;
  } arith_cmd_t;

  typedef struct packed {
    logic          done;
    logic [PW-1:0] result;
  } arith_rsp_t;

endpackage

>>> sv/ssub_seg_if.sv
interface ssub_seg_if import ssub_pkg::*;;
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] start_x;
  logic signed [COORD_BITS-1:0] start_y;
  logic signed [COORD_BITS-1:0] start_z;
  logic signed [COORD_BITS-1:0] end_x;
  logic signed [COORD_BITS-1:0] end_y;
  logic signed [COORD_BITS-1:0] end_z;

  modport source (output valid, start_x, start_y, start_z, end_x, end_y, end_z,
                  input ready);
  modport sink (input valid, start_x, start_y, start_z, end_x, end_y, end_z,
                output ready);
endinterface

>>> sv/ssub_point_if.sv
interface ssub_point_if import ssub_pkg::*;;
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] point_x;
  logic signed [COORD_BITS-1:0] point_y;
  logic signed [COORD_BITS-1:0] point_z;
  logic                         last_point;
  logic                         truncated;

  modport source (output valid, point_x, point_y, point_z, last_point, truncated,
                  input ready);
  modport sink (input valid, point_x, point_y, point_z, last_point, truncated,
                output ready);
endinterface

>>> sv/ssub_arith.sv
module ssub_arith import ssub_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  arith_cmd_t cmd,
  output arith_rsp_t rsp
);

  logic          busy;
  logic          done;
  logic [1:0]    op_r;
  logic [CW-1:0] cnt;
  logic [PW-1:0] acc;
  logic [PW-1:0] x;
  logic [DW-1:0] y;
  logic [DW:0]   rem;
  logic [DW-1:0] root;

  logic [DW:0]   dv_t;
  logic          dv_ge;
  logic [DW+2:0] sq_t;
  logic [DW+2:0] sq_trial;
  logic          sq_ge;

  assign dv_t     = {rem[DW-1:0], x[DW-1]};
  assign dv_ge    = dv_t >= {1'b0, y};
  assign sq_t     = {rem, x[PW-1:PW-2]};
  assign sq_trial = {1'b0, root, 2'b01};
  assign sq_ge    = sq_t >= sq_trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
      op_r <= OP_MUL;
    end else begin
      done <= 1'b0;
      if (cmd.start && !busy) begin
        busy <= 1'b1;
        op_r <= cmd.op;
        cnt  <= CW'(DW - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start && !busy) begin
      acc  <= '0;
      root <= '0;
      y    <= cmd.b;
      case (cmd.op)
        OP_MUL: begin
          x   <= {{(PW-DW){1'b0}}, cmd.a[DW-1:0]};
          rem <= '0;
        end
        OP_DIV: begin
          x   <= cmd.a;
          rem <= {1'b0, cmd.a[PW-1:DW]};
        end
        default: begin
          x   <= cmd.a;
          rem <= '0;
        end
      endcase
    end else if (busy) begin
      case (op_r)
        OP_MUL: begin
          if (y[0]) acc <= acc + x;
          x <= {x[PW-2:0], 1'b0};
          y <= {1'b0, y[DW-1:1]};
        end
        OP_DIV: begin
          rem <= dv_ge ? (dv_t - {1'b0, y}) : dv_t;
          x   <= {x[PW-1:DW], x[DW-2:0], dv_ge};
        end
        default: begin
          rem  <= sq_ge ? (DW+1)'(sq_t - sq_trial) : (DW+1)'(sq_t);
          root <= {root[DW-2:0], sq_ge};
          x    <= {x[PW-3:0], 2'b00};
        end
      endcase
    end
  end

  always_comb begin
    rsp.done = done;
    case (op_r)
      OP_MUL:  rsp.result = acc;
      OP_DIV:  rsp.result = {rem[DW-1:0], x[DW-1:0]};
      default: rsp.result = {{(PW-DW){1'b0}}, root};
    endcase
  end

endmodule

>>> sv/segment_subdivider.sv
// flow: per segment the shared bit-serial unit does three squares, square root, step
// division, then a multiply and a divide for each axis per point; only the end point
// goes out (no step division) when the length is at most the step; one segment at a time,
// each further point is computed after the one before is taken, a trailing end point needs
// no unit pass, and a new segment can be taken in the cycle after its last point is taken
// reset: synchronous, active high; idle, no point pending, step_length back to 256
module segment_subdivider import ssub_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [STEP_BITS-1:0] cfg_wdata,
  ssub_seg_if.sink             seg,
  ssub_point_if.source         point
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_SQ_GO   = 4'd1;
  localparam logic [3:0] S_SQ_WAIT = 4'd2;
  localparam logic [3:0] S_RT_GO   = 4'd3;
  localparam logic [3:0] S_RT_WAIT = 4'd4;
  localparam logic [3:0] S_DV_GO   = 4'd5;
  localparam logic [3:0] S_DV_WAIT = 4'd6;
  localparam logic [3:0] S_MU_GO   = 4'd7;
  localparam logic [3:0] S_MU_WAIT = 4'd8;
  localparam logic [3:0] S_QU_GO   = 4'd9;
  localparam logic [3:0] S_QU_WAIT = 4'd10;
  localparam logic [3:0] S_EMIT    = 4'd11;

  localparam logic [DW-1:0] CAP = DW'(MAX_POINTS - 1);

  logic [3:0]            state;
  logic [STEP_BITS-1:0]  step_length;
  logic [COORD_BITS-1:0] origin [3];
  logic [COORD_BITS-1:0] dest [3];
  logic [DW-1:0]         mag [3];
  logic [2:0]            neg;
  logic [1:0]            axis;
  logic [PW-1:0]         sum;
  logic [DW-1:0]         seg_len;
  logic [DW-1:0]         span;
  logic [PW-1:0]         prod;
  logic [NW-1:0]         steps;
  logic [NW-1:0]         idx;
  logic                  extra;
  logic                  trunc;
  logic [COORD_BITS-1:0] pt [3];
  logic                  o_last;

  logic [DW-1:0]         step_eff;
  logic [COORD_BITS-1:0] s_in [3];
  logic [COORD_BITS-1:0] e_in [3];
  logic [DW-1:0]         d_in [3];
  logic [COORD_BITS-1:0] off;
  logic [COORD_BITS-1:0] pnew;
  arith_cmd_t            cmd;
  arith_rsp_t            rsp;

  assign step_eff = (step_length == '0) ? DW'(1) : DW'(step_length);
  assign s_in[0] = seg.start_x;
  assign s_in[1] = seg.start_y;
  assign s_in[2] = seg.start_z;
  assign e_in[0] = seg.end_x;
  assign e_in[1] = seg.end_y;
  assign e_in[2] = seg.end_z;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      d_in[a] = {e_in[a][COORD_BITS-1], e_in[a]} - {s_in[a][COORD_BITS-1], s_in[a]};
    end
  end

  assign off  = rsp.result[COORD_BITS-1:0];
  assign pnew = neg[axis] ? (origin[axis] - off) : (origin[axis] + off);

  always_comb begin
    cmd.start = 1'b0;
    cmd.op    = OP_MUL;
    cmd.a     = {{(PW-DW){1'b0}}, mag[axis]};
    cmd.b     = mag[axis];
    case (state)
      S_SQ_GO: cmd.start = 1'b1;
      S_RT_GO: begin
        cmd.start = 1'b1;
        cmd.op    = OP_SQRT;
        cmd.a     = sum;
      end
      S_DV_GO: begin
        cmd.start = 1'b1;
        cmd.op    = OP_DIV;
        cmd.a     = {{(PW-DW){1'b0}}, seg_len};
        cmd.b     = step_eff;
      end
      S_MU_GO: begin
        cmd.start = 1'b1;
        cmd.b     = span;
      end
      S_QU_GO: begin
        cmd.start = 1'b1;
        cmd.op    = OP_DIV;
        cmd.a     = prod;
        cmd.b     = seg_len;
      end
      default: cmd.start = 1'b0;
    endcase
  end

  ssub_arith u_arith (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .rsp (rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      step_length <= STEP_RESET;
    end else if (cfg_we) begin
      step_length <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (seg.valid) begin
            for (int a = 0; a < 3; a++) begin
              origin[a] <= s_in[a];
              dest[a]   <= e_in[a];
              neg[a]    <= d_in[a][DW-1];
              mag[a]    <= d_in[a][DW-1] ? (DW'(0) - d_in[a]) : d_in[a];
            end
            axis  <= 2'd0;
            sum   <= '0;
            state <= S_SQ_GO;
          end
        end
        S_SQ_GO: state <= S_SQ_WAIT;
        S_SQ_WAIT: begin
          if (rsp.done) begin
            sum <= sum + rsp.result;
            if (axis == 2'd2) begin
              state <= S_RT_GO;
            end else begin
              axis  <= axis + 1'b1;
              state <= S_SQ_GO;
            end
          end
        end
        S_RT_GO: state <= S_RT_WAIT;
        S_RT_WAIT: begin
          if (rsp.done) begin
            seg_len <= rsp.result[DW-1:0];
            if (rsp.result[DW-1:0] <= step_eff) begin
              pt     <= dest;
              o_last <= 1'b1;
              trunc  <= 1'b0;
              state  <= S_EMIT;
            end else begin
              state <= S_DV_GO;
            end
          end
        end
        S_DV_GO: state <= S_DV_WAIT;
        S_DV_WAIT: begin
          if (rsp.done) begin
            if (rsp.result[DW-1:0] > CAP) begin
              steps <= NW'(CAP);
              trunc <= 1'b1;
              extra <= 1'b1;
            end else begin
              steps <= rsp.result[NW-1:0];
              trunc <= 1'b0;
              extra <= rsp.result[PW-1:DW] != '0;
            end
            idx   <= NW'(1);
            span  <= step_eff;
            axis  <= 2'd0;
            state <= S_MU_GO;
          end
        end
        S_MU_GO: state <= S_MU_WAIT;
        S_MU_WAIT: begin
          if (rsp.done) begin
            prod  <= rsp.result;
            state <= S_QU_GO;
          end
        end
        S_QU_GO: state <= S_QU_WAIT;
        S_QU_WAIT: begin
          if (rsp.done) begin
            pt[axis] <= pnew;
            if (axis == 2'd2) begin
              o_last <= !extra && (idx == steps);
              state  <= S_EMIT;
            end else begin
              axis  <= axis + 1'b1;
              state <= S_MU_GO;
            end
          end
        end
        S_EMIT: begin
          if (point.ready) begin
            if (o_last) begin
              state <= S_IDLE;
            end else if (idx == steps) begin
              pt     <= dest;
              o_last <= 1'b1;
            end else begin
              idx   <= idx + 1'b1;
              span  <= span + step_eff;
              axis  <= 2'd0;
              state <= S_MU_GO;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign seg.ready        = state == S_IDLE;
  assign point.valid      = state == S_EMIT;
  assign point.point_x    = pt[0];
  assign point.point_y    = pt[1];
  assign point.point_z    = pt[2];
  assign point.last_point = o_last;
  assign point.truncated  = trunc;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    seg.valid && seg.ready |=> !seg.ready)
    else $error("segment taken but block still ready");

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    point.valid |-> !seg.ready)
    else $error("segment ready while a point is pending");

  a_idle_after_last: assert property (@(posedge clk) disable iff (rst)
    point.valid && point.ready && point.last_point |=> seg.ready)
    else $error("block not idle after last point");

  a_index_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_MU_GO |-> idx <= steps && idx != '0)
    else $error("point index out of range");

endmodule

>>> tb/tb_top.sv
module tb_top;
  import ssub_pkg::*;

  localparam int WATCH_LIMIT = 60000;
  localparam int SETTLE = 400;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] sx, sy, sz;
    logic signed [COORD_BITS-1:0] ex, ey, ez;
  } seg_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] px, py, pz;
    logic                         last;
    logic                         trunc;
  } point_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [STEP_BITS-1:0] cfg_wdata = '0;

  ssub_seg_if   seg_bus();
  ssub_point_if pt_bus();

  segment_subdivider dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .seg(seg_bus), .point(pt_bus)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  point_t pending_points[$];
  logic [STEP_BITS-1:0] spacing = STEP_RESET;
  int snd_pct = 0;
  int rcv_pct = 0;
  bit hold_off = 1'b0;
  int errors = 0;
  int idle_cycles = 0;

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic void queue_point(input point_t p);
    pending_points = {pending_points, p};
  endfunction

  task automatic predict_points(input seg_t s);
    longint st[3], en[3], d[3], mag[3], p[3];
    longint unsigned sum, seg_len, step, steps, span, off;
    bit capped, extra;
    point_t pt;
    st[0] = s.sx; st[1] = s.sy; st[2] = s.sz;
    en[0] = s.ex; en[1] = s.ey; en[2] = s.ez;
    sum = 0;
    for (int a = 0; a < 3; a++) begin
      d[a] = en[a] - st[a];
      mag[a] = d[a] < 0 ? -d[a] : d[a];
      sum += mag[a] * mag[a];
    end
    seg_len = int_sqrt(sum);
    step = (spacing == 0) ? 64'd1 : 64'(spacing);
    if (seg_len <= step) begin
      pt = '{s.ex, s.ey, s.ez, 1'b1, 1'b0};
      queue_point(pt);
      return;
    end
    steps = seg_len / step;
    capped = 1'b0;
    if (steps > MAX_POINTS - 1) begin
      steps = MAX_POINTS - 1;
      capped = 1'b1;
    end
    extra = capped || (steps * step < seg_len);
    for (longint unsigned i = 1; i <= steps; i++) begin
      span = i * step;
      for (int a = 0; a < 3; a++) begin
        off = (mag[a] * span) / seg_len;
        p[a] = st[a] + (d[a] < 0 ? -longint'(off) : longint'(off));
      end
      pt.px = p[0][COORD_BITS-1:0];
      pt.py = p[1][COORD_BITS-1:0];
      pt.pz = p[2][COORD_BITS-1:0];
      pt.last = !extra && i == steps;
      pt.trunc = capped;
      queue_point(pt);
    end
    if (extra) begin
      pt = '{s.ex, s.ey, s.ez, 1'b1, capped};
      queue_point(pt);
    end
  endtask

  task automatic send_seg(input seg_t s);
    while ($urandom_range(99) < snd_pct) begin
      seg_bus.valid <= 1'b0;
      @(negedge clk);
    end
    seg_bus.valid <= 1'b1;
    seg_bus.start_x <= s.sx; seg_bus.start_y <= s.sy; seg_bus.start_z <= s.sz;
    seg_bus.end_x <= s.ex; seg_bus.end_y <= s.ey; seg_bus.end_z <= s.ez;
    @(posedge clk);
    while (!seg_bus.ready) @(posedge clk);
    predict_points(s);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    seg_bus.valid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_spacing(input logic [STEP_BITS-1:0] v);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    spacing = v;
  endtask

  function automatic seg_t make_seg(input longint sx, sy, sz, ex, ey, ez);
    seg_t s;
    s.sx = sx[23:0]; s.sy = sy[23:0]; s.sz = sz[23:0];
    s.ex = ex[23:0]; s.ey = ey[23:0]; s.ez = ez[23:0];
    return s;
  endfunction

  function automatic seg_t rand_seg();
    seg_t s;
    longint st, en, m, d, step, span;
    int k;
    s.sx = 24'($urandom); s.sy = 24'($urandom); s.sz = 24'($urandom);
    s.ex = 24'($urandom); s.ey = 24'($urandom); s.ez = 24'($urandom);
    if ($urandom_range(99) < 4) return s;
    if ($urandom_range(99) < 5) begin
      s.ex = s.sx; s.ey = s.sy; s.ez = s.sz;
      return s;
    end
    step = (spacing == 0) ? 64'sd1 : longint'(spacing);
    k = $urandom_range(5);
    span = k * step + $urandom_range(32'(step));
    m = span / 2 + 1;
    for (int a = 0; a < 3; a++) begin
      st = (a == 0) ? s.sx : (a == 1) ? s.sy : s.sz;
      d = longint'($urandom_range(32'(2 * m))) - m;
      en = st + d;
      if (en > 8388607 || en < -8388608) en = st - d;
      if (en > 8388607) en = 8388607;
      if (en < -8388608) en = -8388608;
      if (a == 0) s.ex = en[23:0];
      else if (a == 1) s.ey = en[23:0];
      else s.ez = en[23:0];
    end
    return s;
  endfunction

  always @(negedge clk) begin
    pt_bus.ready <= hold_off ? 1'b0 : ($urandom_range(99) >= rcv_pct);
  end

  always @(posedge clk) begin
    point_t got, want;
    if (!rst && pt_bus.valid && pt_bus.ready) begin
      got = '{pt_bus.point_x, pt_bus.point_y, pt_bus.point_z,
              pt_bus.last_point, pt_bus.truncated};
      if (pending_points.size() == 0) begin
        $error("unexpected point x=%0d y=%0d z=%0d", got.px, got.py, got.pz);
        errors++;
      end else begin
        want = pending_points.pop_front();
        if (got.px !== want.px) begin
          $error("point_x expected %0d got %0d", want.px, got.px); errors++;
        end
        if (got.py !== want.py) begin
          $error("point_y expected %0d got %0d", want.py, got.py); errors++;
        end
        if (got.pz !== want.pz) begin
          $error("point_z expected %0d got %0d", want.pz, got.pz); errors++;
        end
        if (got.last !== want.last) begin
          $error("last_point expected %0d got %0d", want.last, got.last); errors++;
        end
        if (got.trunc !== want.trunc) begin
          $error("truncated expected %0d got %0d", want.trunc, got.trunc); errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (seg_bus.valid && seg_bus.ready) || (pt_bus.valid && pt_bus.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCH_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  task automatic test_directed();
    write_spacing(256);
    send_seg(make_seg(100, -200, 300, 100, -200, 300));
    send_seg(make_seg(0, 0, 0, 256, 0, 0));
    send_seg(make_seg(0, 0, 0, 0, 257, 0));
    send_seg(make_seg(10, 20, 30, 10, 20, -738));
    send_seg(make_seg(500, -500, 77, -1300, 900, -2000));
    send_seg(make_seg(-8388608, -8388608, -8388608, 8388607, 8388607, 8388607));
    send_seg(make_seg(8388607, 8388607, 8388607, -8388608, -8388608, -8388608));
    send_seg(make_seg(8388607, -8388608, 0, 8388607, -8388608, 0));
    write_spacing(0);
    send_seg(make_seg(0, 0, 0, 5, 0, 0));
    send_seg(make_seg(3, 3, 3, 3, 3, 4));
    send_seg(make_seg(-40, 12, 7, 60, -30, 9));
    write_spacing(1);
    send_seg(make_seg(0, 0, 0, -3, -4, 0));
    send_seg(make_seg(0, 0, 0, 63, 0, 0));
    send_seg(make_seg(0, 0, 0, 0, 0, 64));
    write_spacing(24'hFFFFFF);
    send_seg(make_seg(-8388608, -8388608, -8388608, 8388607, 8388607, 8388607));
    send_seg(make_seg(-8388608, 0, 0, 8388607, 0, 0));
    send_seg(make_seg(1, 2, 3, -4, 5, -6));
  endtask

  task automatic test_random(input int s_pct, input int r_pct,
                             input logic [STEP_BITS-1:0] step, input int count);
    write_spacing(step);
    snd_pct = s_pct;
    rcv_pct = r_pct;
    repeat (count) send_seg(rand_seg());
  endtask

  task automatic test_backpressure();
    write_spacing(128);
    snd_pct = 0;
    rcv_pct = 0;
    fork
      begin
        repeat (8) send_seg(rand_seg());
      end
      begin
        hold_off = 1'b1;
        repeat (3000) @(negedge clk);
        hold_off = 1'b0;
      end
    join
  endtask

  task automatic test_drain_pause();
    write_spacing(300);
    snd_pct = 9;
    rcv_pct = 9;
    repeat (6) send_seg(rand_seg());
    seg_bus.valid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    @(negedge clk);
    repeat (6) send_seg(rand_seg());
  endtask

  initial begin
    seg_bus.valid = 1'b0;
    seg_bus.start_x = '0; seg_bus.start_y = '0; seg_bus.start_z = '0;
    seg_bus.end_x = '0; seg_bus.end_y = '0; seg_bus.end_z = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed();
    test_random(0, 0, 256, 100);
    test_random(85, 0, 1, 100);
    test_random(0, 85, 24'hFFFFFF, 90);
    test_random(9, 9, 24'($urandom_range(2, 5000)), 100);
    test_backpressure();
    test_drain_pause();
    wait_drained();
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/ssub_pkg.sv
sv/ssub_seg_if.sv
sv/ssub_point_if.sv
sv/ssub_arith.sv
sv/segment_subdivider.sv
tb/tb_top.sv
